// ===== design/aema_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio error metrics package
// Shared constants, word types and state record types for the error metrics
// accumulator and its parts.
// ----------------------------------------------------------------------------
package aema_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_W = 3;
	localparam int SMP_W = 16;
	localparam int CNT_W = 32;
	localparam int SUM_W = 63;
	localparam int SQ_W = 2 * SMP_W;
	localparam int NCH_W = 4;
	localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int IDX_W = (ADDR_W > CH_W) ? ADDR_W : CH_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_NUM_CHANNELS = PADDR_W'(0);

	localparam logic [NCH_W-1:0] NUM_CH_RESET = NCH_W'(2);
	localparam logic [NCH_W-1:0] STEREO_CHANNELS = NCH_W'(2);
	localparam logic [CH_W-1:0] LEFT_CH = CH_W'(0);
	localparam logic [CH_W-1:0] RIGHT_CH = CH_W'(1);

	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic signed [SMP_W-1:0] orig_sample;
		logic signed [SMP_W-1:0] test_sample;
	} in_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] chan_count;
		logic [SUM_W-1:0] chan_sq_error;
		logic [SUM_W-1:0] chan_sq_signal;
		logic [SMP_W-1:0] chan_max_error;
		logic [CNT_W-1:0] mid_count;
		logic [SUM_W-1:0] mid_sq_error;
		logic [SUM_W-1:0] mid_sq_signal;
		logic [SMP_W-1:0] mid_max_error;
	} out_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] esum;
		logic [SUM_W-1:0] ssum;
		logic [SMP_W-1:0] peak;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic             en;
		rec_t             base;
		logic [SQ_W-1:0]  sq_err;
		logic [SQ_W-1:0]  sq_sig;
		logic [SMP_W-1:0] abs_err;
	} upd_in_t;

endpackage

// ===== design/aema_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data. A read of the
// entry being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module aema_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

// ===== design/aema_update.sv =====
// ----------------------------------------------------------------------------
// Metrics record update
// Adds one sample to a record when enabled: saturating count, saturating sums of squares
// and the running peak of the absolute error.
// ----------------------------------------------------------------------------
module aema_update (
	input  aema_pkg::upd_in_t upd,
	output aema_pkg::rec_t    rec
);
	import aema_pkg::*;

	logic [SUM_W:0] esum_ext;
	logic [SUM_W:0] ssum_ext;

	assign esum_ext = {1'b0, upd.base.esum} + (SUM_W + 1)'(upd.sq_err);
	assign ssum_ext = {1'b0, upd.base.ssum} + (SUM_W + 1)'(upd.sq_sig);

	always_comb begin
		rec = upd.base;
		if (upd.en) begin
			rec.cnt = (&upd.base.cnt) ? upd.base.cnt : upd.base.cnt + CNT_W'(1);
			rec.esum = esum_ext[SUM_W] ? {SUM_W{1'b1}} : esum_ext[SUM_W-1:0];
			rec.ssum = ssum_ext[SUM_W] ? {SUM_W{1'b1}} : ssum_ext[SUM_W-1:0];
			if (upd.abs_err > upd.base.peak) begin
				rec.peak = upd.abs_err;
			end
		end
	end

endmodule

// ===== design/audio_error_metrics_accumulator.sv =====
// A result word is registered through stage 1, stage 2 and the output register after
// its input word is accepted. A new word is taken only once stage 1 has made both
// passes through the shared squaring multipliers (error square, then signal square).
// Per-channel totals live in an 8-entry RAM read at accept and written back
// from the last stage, with forwarding for back-to-back words on one channel.
// Reset clears all totals at once through per-entry valid bits; no sweep.
// ----------------------------------------------------------------------------
// Audio error metrics accumulator
// Accumulates per-channel sample count, squared error, squared signal and
// peak error, plus the same metrics for the stereo mid signal.
// ----------------------------------------------------------------------------
module audio_error_metrics_accumulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  aema_pkg::in_word_t                  in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output aema_pkg::out_word_t                 out_word,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [aema_pkg::PADDR_W-1:0]        paddr,
	input  logic [aema_pkg::PDATA_W-1:0]        pwdata,
	output logic [aema_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);
	import aema_pkg::*;

	logic [NCH_W-1:0]        num_ch_q;
	logic signed [SMP_W-1:0] held_orig_q;
	logic signed [SMP_W-1:0] held_test_q;
	rec_t                    mid_q;
	logic                    valid_q [MAX_CHANNELS];
	logic                    out_vld_q;
	out_word_t               out_word_q;

	logic                    in_acc;
	logic                    s2_fire;
	logic                    s2_free;
	logic                    s1_move;
	logic                    stereo;
	logic [IDX_W-1:0]        ch_ext;
	logic [ADDR_W-1:0]       in_addr;
	logic                    in_stored;
	logic                    in_upd;
	logic                    in_hit;
	logic signed [SMP_W:0]   in_err;
	logic [SMP_W:0]          in_err_neg;
	logic [SMP_W-1:0]        in_ae;
	logic [SMP_W-1:0]        in_ax;
	logic signed [SMP_W:0]   osum;
	logic signed [SMP_W:0]   tsum;
	logic signed [SMP_W:0]   osum_t;
	logic signed [SMP_W:0]   tsum_t;

	logic                    vld_s1;
	logic                    ph_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic                    stored_s1;
	logic                    hit_s1;
	logic                    upd_s1;
	logic                    mid_s1;
	logic [SMP_W-1:0]        ae_s1;
	logic [SMP_W-1:0]        ax_s1;
	logic signed [SMP_W-1:0] xm_s1;
	logic signed [SMP_W-1:0] ym_s1;
	logic [SQ_W-1:0]         sqe_s1;
	logic [SQ_W-1:0]         sqe_mid_s1;
	rec_t                    base_s1;

	logic signed [SMP_W:0]   mid_err;
	logic [SMP_W:0]          mid_err_neg;
	logic [SMP_W-1:0]        mid_ae;
	logic [SMP_W-1:0]        mid_ax;
	logic [SMP_W-1:0]        xm_neg;
	logic [SQ_W-1:0]         mul_chan;
	logic [SQ_W-1:0]         mul_mid;
	logic                    fwd;
	rec_t                    base_next;

	logic                    vld_s2;
	logic [ADDR_W-1:0]       addr_s2;
	logic                    stored_s2;
	logic                    upd_s2;
	logic                    mid_s2;
	rec_t                    base_s2;
	logic [SQ_W-1:0]         sqe_s2;
	logic [SQ_W-1:0]         sqs_s2;
	logic [SMP_W-1:0]        ae_s2;
	logic [SQ_W-1:0]         sqe_mid_s2;
	logic [SQ_W-1:0]         sqs_mid_s2;
	logic [SMP_W-1:0]        aem_s2;

	upd_in_t                 chan_upd;
	upd_in_t                 mid_upd;
	rec_t                    chan_new;
	rec_t                    mid_new;

	logic                    ram_we;
	logic [REC_W-1:0]        ram_rdata;

	// Configuration port.
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_NUM_CHANNELS) begin
			prdata = PDATA_W'(num_ch_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q <= NUM_CH_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_NUM_CHANNELS)) begin
			num_ch_q <= pwdata[NCH_W-1:0];
		end
	end

	// Handshake and stage movement.
	assign s2_fire = vld_s2 && (!out_vld_q || !out_stall);
	assign s2_free = !vld_s2 || s2_fire;
	assign s1_move = vld_s1 && ph_s1 && s2_free;
	assign in_stall = vld_s1 && !s1_move;
	assign in_acc = in_valid && !in_stall;

	// Input decode.
	assign stereo = (num_ch_q == STEREO_CHANNELS);
	assign ch_ext = IDX_W'(in_word.channel);
	assign in_addr = ch_ext[ADDR_W-1:0];
	assign in_stored = {1'b0, ch_ext} < (IDX_W + 1)'(MAX_CHANNELS);
	assign in_upd = in_stored && (NCH_W'(in_word.channel) < num_ch_q);
	assign in_hit = in_stored && (valid_q[in_addr] || (ram_we && (addr_s2 == in_addr)));

	assign in_err = {in_word.test_sample[SMP_W-1], in_word.test_sample}
		- {in_word.orig_sample[SMP_W-1], in_word.orig_sample};
	assign in_err_neg = -in_err;
	assign in_ae = in_err[SMP_W] ? in_err_neg[SMP_W-1:0] : in_err[SMP_W-1:0];
	assign in_ax = in_word.orig_sample[SMP_W-1] ? -in_word.orig_sample : in_word.orig_sample;

	// Mid sample: sum halved with truncation toward zero.
	assign osum = {held_orig_q[SMP_W-1], held_orig_q}
		+ {in_word.orig_sample[SMP_W-1], in_word.orig_sample};
	assign tsum = {held_test_q[SMP_W-1], held_test_q}
		+ {in_word.test_sample[SMP_W-1], in_word.test_sample};
	assign osum_t = osum + (SMP_W + 1)'(osum[SMP_W]);
	assign tsum_t = tsum + (SMP_W + 1)'(tsum[SMP_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_orig_q <= '0;
			held_test_q <= '0;
		end else if (in_acc && in_upd && stereo && (in_word.channel == LEFT_CH)) begin
			held_orig_q <= in_word.orig_sample;
			held_test_q <= in_word.test_sample;
		end
	end

	// Stage 1: two passes through the multipliers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ph_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
			ph_s1 <= 1'b0;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end else if (vld_s1 && !ph_s1) begin
			ph_s1 <= 1'b1;
		end
	end

	assign mid_err = {ym_s1[SMP_W-1], ym_s1} - {xm_s1[SMP_W-1], xm_s1};
	assign mid_err_neg = -mid_err;
	assign mid_ae = mid_err[SMP_W] ? mid_err_neg[SMP_W-1:0] : mid_err[SMP_W-1:0];
	assign xm_neg = -xm_s1;
	assign mid_ax = xm_s1[SMP_W-1] ? xm_neg : xm_s1;

	assign mul_chan = SQ_W'(ph_s1 ? ax_s1 : ae_s1) * SQ_W'(ph_s1 ? ax_s1 : ae_s1);
	assign mul_mid = SQ_W'(ph_s1 ? mid_ax : mid_ae) * SQ_W'(ph_s1 ? mid_ax : mid_ae);

	assign fwd = vld_s2 && stored_s2 && stored_s1 && (addr_s2 == addr_s1);

	always_comb begin
		if (fwd) begin
			base_next = chan_new;
		end else if (hit_s1) begin
			base_next = rec_t'(ram_rdata);
		end else begin
			base_next = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1 <= in_addr;
			stored_s1 <= in_stored;
			hit_s1 <= in_hit;
			upd_s1 <= in_upd;
			mid_s1 <= in_upd && stereo && (in_word.channel == RIGHT_CH);
			ae_s1 <= in_ae;
			ax_s1 <= in_ax;
			xm_s1 <= osum_t[SMP_W:1];
			ym_s1 <= tsum_t[SMP_W:1];
		end
		if (vld_s1 && !ph_s1) begin
			sqe_s1 <= mul_chan;
			sqe_mid_s1 <= mul_mid;
			base_s1 <= base_next;
		end
	end

	// Stage 2: saturating update, write-back and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_move) begin
			vld_s2 <= 1'b1;
		end else if (s2_fire) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			addr_s2 <= addr_s1;
			stored_s2 <= stored_s1;
			upd_s2 <= upd_s1;
			mid_s2 <= mid_s1;
			base_s2 <= base_s1;
			sqe_s2 <= sqe_s1;
			sqs_s2 <= mul_chan;
			ae_s2 <= ae_s1;
			sqe_mid_s2 <= sqe_mid_s1;
			sqs_mid_s2 <= mul_mid;
			aem_s2 <= mid_ae;
		end
	end

	assign chan_upd = '{en: upd_s2, base: base_s2, sq_err: sqe_s2, sq_sig: sqs_s2,
		abs_err: ae_s2};
	assign mid_upd = '{en: mid_s2, base: mid_q, sq_err: sqe_mid_s2, sq_sig: sqs_mid_s2,
		abs_err: aem_s2};

	aema_update u_chan_update (
		.upd (chan_upd),
		.rec (chan_new)
	);

	aema_update u_mid_update (
		.upd (mid_upd),
		.rec (mid_new)
	);

	assign ram_we = s2_fire && upd_s2;

	aema_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s2),
		.wdata (chan_new),
		.re    (in_acc),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (ram_we) begin
			valid_q[addr_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= '0;
		end else if (s2_fire && mid_s2) begin
			mid_q <= mid_new;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s2_fire) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			out_word_q <= '{chan_count: chan_new.cnt, chan_sq_error: chan_new.esum,
				chan_sq_signal: chan_new.ssum, chan_max_error: chan_new.peak,
				mid_count: mid_new.cnt, mid_sq_error: mid_new.esum,
				mid_sq_signal: mid_new.ssum, mid_max_error: mid_new.peak};
		end
	end

	assign out_valid = out_vld_q;
	assign out_word = out_word_q;

`ifndef SYNTHESIS
	a_accept_free_mult: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !(vld_s1 && !ph_s1))
		else $error("Word accepted while the multipliers are on their first pass.");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(addr_s2)])
		else $error("Written channel entry is not marked valid.");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(s2_fire && mid_s2) |=> $stable(mid_q))
		else $error("Mid totals changed without a mid update.");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !s2_fire |=> vld_s2 && $stable(base_s2))
		else $error("Stalled last stage lost its word.");
`endif

endmodule

// ===== verif/tb_audio_error_metrics_accumulator.sv =====
// ----------------------------------------------------------------------------
// Audio error metrics accumulator testbench
// Feeds sample pairs through the stream port under random source gaps and sink
// stalls, reprograms the channel count between phases over the register port,
// and checks every result word against an internal running-totals predictor.
// ----------------------------------------------------------------------------
module tb_audio_error_metrics_accumulator;

	import aema_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MID_DIV = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	audio_error_metrics_accumulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	in_word_t pending_words[$];
	out_word_t expected_totals[$];

	rec_t chan_tally[MAX_CHANNELS];
	rec_t mid_tally = '0;
	int left_orig = 0;
	int left_test = 0;
	logic [NCH_W-1:0] cfg_channels = NUM_CH_RESET;

	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int mid_updates = 0;
	int ignored_words = 0;
	int phases = 0;
	int idle_cycles = 0;
	int src_gap = 0;
	int snk_gap = 0;
	bit no_gaps = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] acc, logic [63:0] inc);
		logic [63:0] s;
		s = {1'b0, acc} + inc;
		return s[63] ? '1 : s[SUM_W-1:0];
	endfunction

	function automatic rec_t tally_add(rec_t r, int x, int y);
		int e;
		logic [63:0] ae;
		logic [63:0] ax;
		e = y - x;
		ae = (e < 0) ? 64'(-e) : 64'(e);
		ax = (x < 0) ? 64'(-x) : 64'(x);
		r.cnt = (r.cnt == '1) ? r.cnt : r.cnt + CNT_W'(1);
		r.esum = sum_sat(r.esum, ae * ae);
		r.ssum = sum_sat(r.ssum, ax * ax);
		if (ae > 64'(r.peak)) begin
			r.peak = ae[SMP_W-1:0];
		end
		return r;
	endfunction

	function automatic out_word_t predict_totals(in_word_t w);
		int x;
		int y;
		out_word_t r;
		bit stereo;
		x = int'($signed(w.orig_sample));
		y = int'($signed(w.test_sample));
		stereo = (cfg_channels == STEREO_CHANNELS);
		if (NCH_W'(w.channel) < cfg_channels) begin
			chan_tally[w.channel] = tally_add(chan_tally[w.channel], x, y);
			if (stereo && w.channel == LEFT_CH) begin
				left_orig = x;
				left_test = y;
			end else if (stereo && w.channel == RIGHT_CH) begin
				mid_tally = tally_add(mid_tally, (left_orig + x) / MID_DIV,
					(left_test + y) / MID_DIV);
				mid_updates++;
			end
		end else begin
			ignored_words++;
		end
		r.chan_count = chan_tally[w.channel].cnt;
		r.chan_sq_error = chan_tally[w.channel].esum;
		r.chan_sq_signal = chan_tally[w.channel].ssum;
		r.chan_max_error = chan_tally[w.channel].peak;
		r.mid_count = mid_tally.cnt;
		r.mid_sq_error = mid_tally.esum;
		r.mid_sq_signal = mid_tally.ssum;
		r.mid_max_error = mid_tally.peak;
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Source side: a word is taken at an edge with valid high and stall low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_totals.push_back(predict_totals(in_word));
				words_in++;
			end
			if (!in_valid || !in_stall) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 && !no_gaps
						&& $urandom_range(0, 5) == 0) begin
					src_gap = $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_word <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Sink side: random stall bursts and the result check.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				words_out++;
				if (expected_totals.size() == 0) begin
					$error("result word with no input word outstanding");
					errors++;
				end else begin
					want = expected_totals.pop_front();
					check_field("chan_count", 64'(want.chan_count),
						64'(out_word.chan_count));
					check_field("chan_sq_error", 64'(want.chan_sq_error),
						64'(out_word.chan_sq_error));
					check_field("chan_sq_signal", 64'(want.chan_sq_signal),
						64'(out_word.chan_sq_signal));
					check_field("chan_max_error", 64'(want.chan_max_error),
						64'(out_word.chan_max_error));
					check_field("mid_count", 64'(want.mid_count),
						64'(out_word.mid_count));
					check_field("mid_sq_error", 64'(want.mid_sq_error),
						64'(out_word.mid_sq_error));
					check_field("mid_sq_signal", 64'(want.mid_sq_signal),
						64'(out_word.mid_sq_signal));
					check_field("mid_max_error", 64'(want.mid_max_error),
						64'(out_word.mid_max_error));
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				out_stall <= 1'b1;
			end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
				snk_gap = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_audio_error_metrics_accumulator: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic void push_pair(logic [CH_W-1:0] ch, logic [SMP_W-1:0] o,
			logic [SMP_W-1:0] t);
		in_word_t w;
		w.channel = ch;
		w.orig_sample = o;
		w.test_sample = t;
		pending_words.push_back(w);
	endfunction

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 63)) - 16'd32;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic void push_random(int nch, int count);
		int seq_ch;
		int span;
		logic [SMP_W-1:0] o;
		logic [SMP_W-1:0] t;
		logic [CH_W-1:0] ch;
		seq_ch = 0;
		span = (nch == 0 || nch > MAX_CHANNELS) ? MAX_CHANNELS : nch;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				ch = CH_W'($urandom_range(0, MAX_CHANNELS - 1));
			end else begin
				ch = CH_W'(seq_ch);
				seq_ch = (seq_ch + 1) % span;
			end
			o = pick_sample();
			t = $urandom_range(0, 1) ? o + 16'($urandom_range(0, 511)) - 16'd256
				: pick_sample();
			push_pair(ch, o, t);
		end
	endfunction

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || expected_totals.size() > 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_channels(logic [NCH_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_NUM_CHANNELS;
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cfg_channels = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[NCH_W-1:0] !== value) begin
			$error("num_channels: expected %0d, got %0d", value, prdata[NCH_W-1:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		phases++;
	endtask

	task automatic run_phase(logic [NCH_W-1:0] nch, int count);
		wait_drained();
		set_channels(nch);
		push_random(nch, count);
	endtask

	initial begin
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			chan_tally[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		push_pair(RIGHT_CH, -16'sd1000, 16'sd500);
		push_pair(3'd7, 16'sd5, 16'sd5);
		push_pair(LEFT_CH, 16'h8000, 16'h7fff);
		push_pair(RIGHT_CH, 16'h7fff, 16'h8000);
		push_pair(LEFT_CH, 16'h8000, 16'h8000);
		push_pair(RIGHT_CH, 16'h8000, 16'h8000);
		push_pair(LEFT_CH, 16'h7fff, 16'h7fff);
		push_pair(RIGHT_CH, 16'h7fff, 16'h7fff);
		push_pair(LEFT_CH, -16'sd3, 16'sd0);
		push_pair(RIGHT_CH, 16'sd0, 16'sd0);
		push_pair(LEFT_CH, 16'sd1, -16'sd2);
		push_pair(RIGHT_CH, 16'sd2, -16'sd1);
		push_pair(RIGHT_CH, 16'sd100, 16'sd200);
		push_pair(LEFT_CH, 16'h5555, 16'haaaa);
		push_pair(RIGHT_CH, 16'haaaa, 16'h5555);
		push_pair(3'd2, 16'sd1, 16'sd2);
		push_pair(3'd5, 16'h8000, 16'h7fff);
		push_pair(LEFT_CH, 16'sd0, 16'sd0);
		push_pair(RIGHT_CH, 16'sd0, 16'sd0);
		push_pair(LEFT_CH, 16'sd12345, -16'sd23456);
		push_pair(RIGHT_CH, -16'sd1, 16'sd1);
		push_pair(3'd7, 16'hffff, 16'h0000);
		push_random(2, 120);

		run_phase(4'd1, 50);
		run_phase(4'd0, 15);
		run_phase(4'd8, 80);
		run_phase(4'd15, 40);
		run_phase(4'd3, 50);
		run_phase(4'd9, 30);
		run_phase(4'd2, 150);

		// The tail of the run goes through with neither side idling.
		while (pending_words.size() >= 40) begin
			@(negedge clk);
		end
		no_gaps = 1'b1;
		wait_drained();

		$display("Checked %0d result words for %0d input words over %0d channel settings.",
			words_out, words_in, phases + 1);
		$display("Stereo mid updates: %0d; words outside the channel count: %0d.",
			mid_updates, ignored_words);
		if (errors == 0) begin
			$display("tb_audio_error_metrics_accumulator: PASS");
		end else begin
			$display("tb_audio_error_metrics_accumulator: FAIL");
		end
		$finish;
	end

endmodule
